FILE: rtl/core/cpf_pkg.sv
// cpf_pkg: shared types, constants and CRC-32 byte tables for the CRC forcing block.
// No dependencies; imported by every module under rtl/core.
package cpf_pkg;

    localparam int          C_POS_W     = 13;
    localparam int          C_CFG_IDX_W = 2;
    localparam logic [31:0] C_POLY      = 32'hEDB88320;
    localparam logic [31:0] C_ONES      = 32'hFFFFFFFF;
    localparam logic [31:0] C_TOP_BIT   = 32'h80000000;

    // register indexes on the configuration port
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TARGET = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_POS    = 2'd1;

    // status codes
    localparam logic [1:0] C_ST_OK      = 2'd0;
    localparam logic [1:0] C_ST_INVALID = 2'd1;
    localparam logic [1:0] C_ST_OVERCAP = 2'd2;

    // message descriptor handed from front to back
    typedef struct packed {
        logic [31:0]        target;
        logic [C_POS_W-1:0] position;
        logic               ovf;
    } t_job;

    typedef logic [31:0] t_tab [256];

    function automatic t_tab f_make_fwd();
        t_tab        tab;
        logic [31:0] c;
        for (int n = 0; n < 256; n++) begin
            c = 32'(n);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? (C_POLY ^ (c >> 1)) : (c >> 1);
            end
            tab[n] = c;
        end
        return tab;
    endfunction

    function automatic t_tab f_make_rev();
        t_tab        tab;
        logic [31:0] c;
        for (int n = 0; n < 256; n++) begin
            c = 32'(n) << 24;
            for (int k = 0; k < 8; k++) begin
                c = ((c & C_TOP_BIT) != 32'd0) ? (((c ^ C_POLY) << 1) | 32'd1) : (c << 1);
            end
            tab[n] = c;
        end
        return tab;
    endfunction

    localparam t_tab C_FWD_TAB = f_make_fwd();
    localparam t_tab C_REV_TAB = f_make_rev();

endpackage

FILE: rtl/core/crc32_patch_bytes_forge.sv
// crc32_patch_bytes_forge: one byte request per cycle; busy is high in reset and while both
// store banks hold closed messages, one in the back end and one queued behind it.
// With the back end idle, the result for a message follows its last byte after a position
// reduction and one store read per byte over both passes; a late position reports after the
// reduction, a short or over-capacity message straight from idle.
// Sync active-low reset idles queue and both ends, store kept; results cannot be stalled.
module crc32_patch_bytes_forge import cpf_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]            i_cfg_wdata,
    output logic                   o_valid,
    output logic [31:0]            o_patch_word,
    output logic [1:0]             o_status
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN+1);

    // front -> store write port
    logic          wr_en, wr_bank;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // front -> queue -> back descriptors
    logic          push, pop, q_valid, q_full;
    t_job          f_job, q_job;
    logic [LW-1:0] f_len, q_len;

    // Front: counts bytes into the free bank and snapshots the request
    // registers when the last byte arrives.
    cpf_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (q_full),
        .o_busy      (busy),
        .o_wr_en     (wr_en),
        .o_wr_bank   (wr_bank),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_job       (f_job),
        .o_len       (f_len)
    );

    // Queue: one entry per store bank, so a full queue means no free bank.
    cpf_queue #(.LW(LW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_len   (f_len),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job),
        .o_len   (q_len)
    );

    // Back: owns the store, pops a descriptor only once its result is computed,
    // which keeps that bank reserved for the whole computation.
    cpf_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_bank    (wr_bank),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_valid      (q_valid),
        .i_job        (q_job),
        .i_len        (q_len),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_patch_word (o_patch_word),
        .o_status     (o_status)
    );

endmodule

FILE: rtl/core/cpf_front.sv
// cpf_front: byte intake, length/overflow tracking, config registers, store write port.
// Depends on cpf_pkg; feeds cpf_queue and the store inside cpf_back.
module cpf_front import cpf_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_full,
    output logic                   o_busy,
    output logic                   o_wr_en,
    output logic                   o_wr_bank,
    output logic [$clog2(MAX_LEN)-1:0]   o_wr_addr,
    output logic [7:0]             o_wr_data,
    output logic                   o_push,
    output t_job                   o_job,
    output logic [$clog2(MAX_LEN+1)-1:0] o_len
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN+1);

    logic [LW-1:0]      r_count, n_len;
    logic               r_ovf;
    logic               r_bank;
    logic [31:0]        r_target;
    logic [C_POS_W-1:0] r_position;
    logic               accept, room;

    assign o_busy = i_full | ~i_rst_n;
    assign accept = i_start & ~o_busy;
    assign room   = r_count < LW'(MAX_LEN);
    assign n_len  = room ? r_count + LW'(1) : r_count;

    assign o_wr_en   = accept & room;
    assign o_wr_bank = r_bank;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = i_data_byte;

    assign o_push       = accept & i_last_byte;
    assign o_job.target   = r_target;
    assign o_job.position = r_position;
    assign o_job.ovf      = r_ovf | ~room;
    assign o_len          = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_bank     <= 1'b0;
            r_target   <= '0;
            r_position <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_REG_TARGET: r_target   <= i_cfg_wdata;
                    C_REG_POS:    r_position <= i_cfg_wdata[C_POS_W-1:0];
                    default:      ;
                endcase
            end
            if (accept) begin
                if (i_last_byte) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_bank  <= ~r_bank;
                end else begin
                    r_count <= n_len;
                    r_ovf   <= r_ovf | ~room;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(MAX_LEN))
        else $error("byte count beyond capacity");
`endif

endmodule

FILE: rtl/core/cpf_queue.sv
// cpf_queue: two-entry descriptor queue between front and back, one per store bank.
// Depends on cpf_pkg.
module cpf_queue import cpf_pkg::*; #(
    parameter int LW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic [LW-1:0] i_len,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output t_job          o_job,
    output logic [LW-1:0] o_len
);
    t_job          r_job [2];
    logic [LW-1:0] r_len [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_job   = r_job[r_rp];
    assign o_len   = r_len[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wp] <= i_job;
            r_len[r_wp] <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/cpf_back.sv
// cpf_back: two-bank message store, position reduction, forward and reverse CRC passes.
// Depends on cpf_pkg; fed by cpf_front (store writes) and cpf_queue (descriptors).
module cpf_back import cpf_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic                   i_wr_bank,
    input  logic [$clog2(MAX_LEN)-1:0]   i_wr_addr,
    input  logic [7:0]             i_wr_data,
    input  logic                   i_valid,
    input  t_job                   i_job,
    input  logic [$clog2(MAX_LEN+1)-1:0] i_len,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [31:0]            o_patch_word,
    output logic [1:0]             o_status
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN+1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_FWD  = 3'd3;
    localparam logic [2:0] S_REV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // bank bit on top of the address, so each bank spans the full address range
    logic [7:0] mem [2**(AW+1)];
    logic [7:0] r_rd_data;

    logic [2:0]         r_state, n_state;
    logic               r_bank;
    logic [LW-1:0]      r_len, n_len;
    logic [31:0]        r_target, n_target;
    logic               r_neg, n_neg;
    logic [C_POS_W-1:0] r_mag, n_mag;
    logic [LW-1:0]      r_rem, n_rem;
    logic [3:0]         r_bit, n_bit;
    logic [LW-1:0]      r_pos, n_pos;
    logic [LW-1:0]      r_idx, n_idx;
    logic [31:0]        r_fwd, n_fwd;
    logic [31:0]        r_rev, n_rev;
    logic               r_pv, n_pv;
    logic               r_psel, n_psel;
    logic [7:0]         r_pfb, n_pfb;
    logic               r_valid, n_valid;
    logic [31:0]        r_patch, n_patch;
    logic [1:0]         r_status, n_status;

    logic [LW:0]   trial;
    logic [LW-1:0] idx_m1, off;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rev_in;

    assign trial   = {r_rem, r_mag[C_POS_W-1]};
    assign idx_m1  = r_idx - LW'(1);
    assign off     = idx_m1 - r_pos;
    assign rd_addr = (r_state == S_REV) ? idx_m1[AW-1:0] : r_idx[AW-1:0];
    assign rev_in  = r_psel ? r_pfb : r_rd_data;
    assign o_pop   = r_state == S_EMIT;

    // store: one write port from the front, one registered read port here
    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[{i_wr_bank, i_wr_addr}] <= i_wr_data;
        r_rd_data <= mem[{r_bank, rd_addr}];
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_target = r_target;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_fwd    = r_fwd;
        n_rev    = r_rev;
        n_pv     = 1'b0;
        n_psel   = r_psel;
        n_pfb    = r_pfb;
        n_valid  = 1'b0;
        n_patch  = r_patch;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_len    = i_len;
                    n_target = i_job.target;
                    n_neg    = i_job.position[C_POS_W-1];
                    n_mag    = i_job.position[C_POS_W-1] ? (~i_job.position + C_POS_W'(1))
                                                         : i_job.position;
                    n_rem    = '0;
                    n_bit    = 4'(C_POS_W-1);
                    n_patch  = '0;
                    if (i_job.ovf) begin
                        n_status = C_ST_OVERCAP;
                        n_state  = S_EMIT;
                    end else if (i_len < LW'(4)) begin
                        n_status = C_ST_INVALID;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // restoring remainder, one bit of |position| a cycle
                n_rem = (trial >= {1'b0, r_len}) ? LW'(trial - {1'b0, r_len}) : trial[LW-1:0];
                n_mag = r_mag << 1;
                n_bit = r_bit - 4'd1;
                if (r_bit == 4'd0) n_state = S_POS;
            end
            S_POS: begin
                n_pos = (r_neg && r_rem != '0) ? r_len - r_rem : r_rem;
                if (r_neg ? (r_rem != '0 && r_rem < LW'(4))
                          : ({1'b0, r_rem} + (LW+1)'(4) > {1'b0, r_len})) begin
                    n_status = C_ST_INVALID;
                    n_state  = S_EMIT;
                end else begin
                    n_idx   = '0;
                    n_fwd   = C_ONES;
                    n_state = S_FWD;
                end
            end
            S_FWD: begin
                if (r_pv) n_fwd = (r_fwd >> 8) ^ C_FWD_TAB[r_fwd[7:0] ^ r_rd_data];
                if (r_idx != r_pos) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + LW'(1);
                end else if (!r_pv) begin
                    n_idx   = r_len;
                    n_rev   = r_target ^ C_ONES;
                    n_state = S_REV;
                end
            end
            S_REV: begin
                if (r_pv) n_rev = (r_rev << 8) ^ C_REV_TAB[r_rev[31:24]] ^ {24'd0, rev_in};
                if (r_idx != r_pos) begin
                    n_pv   = 1'b1;
                    n_idx  = idx_m1;
                    // the four patch bytes come from the forward register, not the store
                    n_psel = off < LW'(4);
                    n_pfb  = 8'(r_fwd >> {off[1:0], 3'b000});
                end else if (!r_pv) begin
                    n_patch  = r_rev;
                    n_status = C_ST_OK;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_valid <= n_valid;
            if (o_pop) r_bank <= ~r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_target <= n_target;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_fwd    <= n_fwd;
        r_rev    <= n_rev;
        r_psel   <= n_psel;
        r_pfb    <= n_pfb;
        r_patch  <= n_patch;
        r_status <= n_status;
    end

    assign o_valid      = r_valid;
    assign o_patch_word = r_patch;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

FILE: test/crc32_patch_bytes_forge_tb.sv
// Self-checking testbench for crc32_patch_bytes_forge: message bytes go in as start/busy
// requests and each o_valid strobe is checked against a built-in CRC forcing predictor.
// Depends on cpf_pkg (register indexes, status codes, polynomial) and the block itself.
module crc32_patch_bytes_forge_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpf_pkg::*;

    localparam int MSG_CAP      = 4096;
    localparam int DRAIN_CYCLES = 48;     // idle margin once the last result is out
    localparam int RANDOM_BYTES = 1400;

    // indexes that decode to no register at all
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SPARE_A = 2'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SPARE_B = 2'd3;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        logic [31:0] patch;
        logic [1:0]  status;
    } t_patch_result;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs; every input has a known value at 0
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic [7:0]             i_data_byte = 8'd0;
    logic                   i_last_byte = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx   = C_REG_TARGET;
    logic [31:0]            i_cfg_wdata = 32'd0;
    logic                   o_valid;
    logic [31:0]            o_patch_word;
    logic [1:0]             o_status;

    always #2 i_clk = ~i_clk;

    crc32_patch_bytes_forge #(
        .MAX_LEN(MSG_CAP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_patch_word(o_patch_word),
        .o_status    (o_status)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the message and of the registers
    // ------------------------------------------------------------------
    logic [7:0]      msg_mem [MSG_CAP];
    int unsigned     msg_len     = 0;
    bit              msg_ovf     = 1'b0;
    logic [31:0]     want_target = 32'd0;
    logic [12:0]     want_pos    = 13'd0;

    t_patch_result   patch_due [$];   // results still owed by the block, oldest first
    t_patch_result   patch_got;
    int              mismatch_count = 0;
    int              burst_left     = 8;

    // one byte of the reflected CRC, bit-serial
    function automatic logic [31:0] crc_fwd_byte(logic [31:0] r, logic [7:0] b);
        r = r ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ C_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // one byte of the CRC run backwards: undo the top byte, shift in v
    function automatic logic [31:0] crc_back_byte(logic [31:0] r, logic [7:0] v);
        logic [31:0] t;
        t = {r[31:24], 24'd0};
        for (int k = 0; k < 8; k++) begin
            t = t[31] ? (((t ^ C_POLY) << 1) | 32'd1) : (t << 1);
        end
        return (r << 8) ^ t ^ {24'd0, v};
    endfunction

    // Tracks one accepted request; at the closing byte works out the patch
    task automatic forge_track_byte(input logic [7:0] b, input logic last);
        t_patch_result res;
        int            p;
        int            r;
        int unsigned   pos;
        logic [31:0]   fwd;
        logic [31:0]   back;
        logic [7:0]    v;
        if (msg_len < MSG_CAP) begin
            msg_mem[msg_len] = b;
            msg_len++;
        end else begin
            msg_ovf = 1'b1;
        end
        if (!last) return;

        res = '{patch: 32'd0, status: C_ST_OK};
        if (msg_ovf) begin
            res.status = C_ST_OVERCAP;
        end else if (msg_len < 4) begin
            res.status = C_ST_INVALID;
        end else begin
            p = $signed(want_pos);
            r = p % int'(msg_len);          // truncates towards zero, as intended
            if (r < 0) r += int'(msg_len);
            pos = r;
            if (pos > msg_len - 4) begin
                res.status = C_ST_INVALID;
            end else begin
                fwd = C_ONES;
                for (int unsigned i = 0; i < pos; i++) begin
                    fwd = crc_fwd_byte(fwd, msg_mem[i]);
                end
                back = want_target ^ C_ONES;
                for (int unsigned i = msg_len; i > pos; i--) begin
                    // the four patch slots hold the forward register, little-endian
                    if (i - 1 < pos + 4) v = 8'(fwd >> (8 * (i - 1 - pos)));
                    else                 v = msg_mem[i - 1];
                    back = crc_back_byte(back, v);
                end
                res.patch = back;
            end
        end
        patch_due.push_back(res);
        msg_len = 0;
        msg_ovf = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (patch_due.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result: expected none actual patch %h status %0d",
                         $time, o_patch_word, o_status);
            end else begin
                patch_got = patch_due.pop_front();
                if (o_patch_word !== patch_got.patch) begin
                    mismatch_count++;
                    $display("%0t patch_word mismatch: expected %h actual %h",
                             $time, patch_got.patch, o_patch_word);
                end
                if (o_status !== patch_got.status) begin
                    mismatch_count++;
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, patch_got.status, o_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drops start for a pause; the data lines carry noise meanwhile
    task automatic sender_pause(input int n);
        start       <= 1'b0;
        i_data_byte <= 8'($urandom);
        i_last_byte <= 1'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // Offers one request and holds it until the block takes it. Start stays
    // high into the next request unless the burst runs out.
    task automatic send_byte(input logic [7:0] b, input logic last);
        start       <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        forge_track_byte(b, last);
        burst_left--;
        if (burst_left <= 0) begin
            sender_pause($urandom_range(1, 8));
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic send_message(input int len, input t_fill fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Waits for every owed result, then a margin so the back end is at rest
    task automatic settle_block();
        start <= 1'b0;
        @(posedge i_clk);
        while (patch_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called once settle_block has run
    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == C_REG_TARGET)   want_target = data;
        else if (idx == C_REG_POS) want_pos    = data[12:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // position write with junk in the unused upper bits of the data word
    task automatic write_pos(input logic [12:0] pos);
        logic [31:0] wd;
        wd       = $urandom;
        wd[12:0] = pos;
        write_reg(C_REG_POS, wd);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // registers at their reset values: target 0, position 0
    task automatic test_reset_defaults();
        send_message(4, FILL_RANDOM);
        settle_block();
    endtask

    // fewer than four bytes can never hold a patch
    task automatic test_short_messages();
        send_message(1, FILL_RANDOM);
        send_message(2, FILL_ONES);
        send_message(3, FILL_ZERO);
        settle_block();
    endtask

    // most positive and most negative position, all-ones and zero targets
    task automatic test_position_extremes();
        write_reg(C_REG_TARGET, C_ONES);
        write_pos(13'h0FFF);                // 4095 mod 7 lands on 0
        send_message(7, FILL_ONES);
        settle_block();
        write_reg(C_REG_TARGET, 32'd0);
        write_pos(13'h1000);                // -4096 mod 8 lands on 0
        send_message(8, FILL_ZERO);
        settle_block();
    endtask

    // positions past length-4, and the last legal slot counted from the end
    task automatic test_late_position();
        write_reg(C_REG_TARGET, $urandom);
        write_pos(13'd3);
        send_message(6, FILL_RANDOM);       // too late
        settle_block();
        write_pos(13'h1FFF);                // -1: too late
        send_message(6, FILL_RANDOM);
        settle_block();
        write_pos(13'h1FFC);                // -4: patch fills the tail
        send_message(6, FILL_RANDOM);
        settle_block();
    endtask

    // writes to the spare indexes must leave both registers alone
    task automatic test_spare_index();
        write_reg(C_REG_SPARE_A, $urandom);
        write_reg(C_REG_SPARE_B, $urandom);
        send_message(9, FILL_RANDOM);
        settle_block();
    endtask

    // a message filling the store exactly, patch in the last four bytes
    task automatic test_full_store();
        write_reg(C_REG_TARGET, $urandom);
        write_pos(13'h1FFC);
        send_message(MSG_CAP, FILL_RANDOM);
        settle_block();
    endtask

    // bytes past capacity are dropped; the next message must start clean
    task automatic test_over_capacity();
        send_message(MSG_CAP + 4, FILL_RANDOM);
        send_message(12, FILL_RANDOM);
        settle_block();
    endtask

    // phases of random settings, each carrying several random messages
    task automatic test_random_phases();
        int          sent_bytes;
        int          len;
        logic [12:0] pos;
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            case ($urandom_range(0, 2))
                0:       write_reg(C_REG_TARGET, 32'd0);
                1:       write_reg(C_REG_TARGET, C_ONES);
                default: write_reg(C_REG_TARGET, $urandom);
            endcase
            // near positions keep most messages patchable; the rest probe wrap-round
            case ($urandom_range(0, 7))
                0, 1, 2: pos = 13'($urandom_range(0, 12));
                3, 4:    pos = 13'(0 - int'($urandom_range(4, 16)));
                5:       pos = 13'($urandom);
                6:       pos = ($urandom_range(0, 1) != 0) ? 13'h0FFF : 13'h1000;
                default: pos = 13'd0;
            endcase
            write_pos(pos);
            if ($urandom_range(0, 5) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? C_REG_SPARE_A : C_REG_SPARE_B,
                          $urandom);
            end
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(1, 3);
                    1:       len = $urandom_range(41, 160);
                    default: len = $urandom_range(4, 40);
                endcase
                send_message(len, FILL_RANDOM);
                sent_bytes += len;
            end
            settle_block();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_short_messages();
        test_position_extremes();
        test_late_position();
        test_spare_index();
        test_full_store();
        test_over_capacity();
        test_random_phases();

        settle_block();
        if (mismatch_count == 0 && patch_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
